/* rtl/falts_pkg.sv */
// ----------------------------------------------------------------------------
// falts_pkg
// Shared constants and types for the fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falts_pkg;

    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 3;
    localparam int ADDR_BITS   = 32;

    localparam int IN_ADDR_W   = 32;
    localparam int EXT_ADDR_W  = 64;
    localparam int TAG_W       = ADDR_BITS - OFFSET_BITS;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_W   = 2;
    localparam int COUNT_W     = 32;

    typedef logic [TAG_W-1:0]   t_tag;
    typedef logic [WAY_W-1:0]   t_way;
    typedef logic [COUNT_W-1:0] t_count;

    // controller to datapath commands
    typedef struct packed {
        logic load_addr;
        logic exec;
    } t_dp_cmd;

endpackage

/* rtl/falts_req_if.sv */
// ----------------------------------------------------------------------------
// falts_req_if
// Request channel: one byte address per beat.
// ----------------------------------------------------------------------------
interface falts_req_if
    import falts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [IN_ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

/* rtl/falts_rsp_if.sv */
// ----------------------------------------------------------------------------
// falts_rsp_if
// Response channel: hit flag, way used and the two running counters.
// ----------------------------------------------------------------------------
interface falts_rsp_if
    import falts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;

    modport source (output valid, output hit, output way_used, output hit_total,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input hit_total,
                    input miss_total, output ready);
endinterface

/* rtl/fully_assoc_lru_tag_store_unit.sv */
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store_unit
// Steps: the address is loaded, then the lookup/update registers the result beat.
// Throughput: one address at a time; the single lookup/update step of the
//   shared tag store sets this, and a held result stalls the next update.
// Reset: synchronous, active low; clears valid bits and counters, ages go to
//   way index order; tags stay undefined until written.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store_unit
    import falts_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    falts_req_if.sink    i_req,
    falts_rsp_if.source  o_rsp
);

    t_dp_cmd cmd;

    falts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    falts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_address    (i_req.address),
        .o_hit        (o_rsp.hit),
        .o_way_used   (o_rsp.way_used),
        .o_hit_total  (o_rsp.hit_total),
        .o_miss_total (o_rsp.miss_total)
    );

endmodule

/* rtl/falts_ctrl.sv */
// ----------------------------------------------------------------------------
// falts_ctrl
// Sequencer: takes an address, runs one lookup/update step, and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module falts_ctrl
    import falts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    // result register can take a new beat if empty or draining this cycle
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        o_cmd.load_addr = 1'b0;
        o_cmd.exec      = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_addr = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/falts_dp.sv */
// ----------------------------------------------------------------------------
// falts_dp
// Tag store datapath: way tags, valid bits, LRU ages, counters and the
// result register.
// ----------------------------------------------------------------------------
module falts_dp
    import falts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [IN_ADDR_W-1:0] i_address,
    output logic                 o_hit,
    output logic [WAY_OUT_W-1:0] o_way_used,
    output t_count               o_hit_total,
    output t_count               o_miss_total
);

    t_tag   r_tag   [WAYS];
    t_way   r_age   [WAYS];
    logic   r_valid [WAYS];
    t_way   n_age   [WAYS];
    t_tag   r_addr_tag;
    t_count r_hits, n_hits;
    t_count r_misses, n_misses;
    logic   r_hit;
    t_way   r_way;

    logic                    found;
    logic                    have_free;
    t_way                    hit_way;
    t_way                    free_way;
    t_way                    lru_way;
    t_way                    sel_way;
    t_way                    sel_age;
    logic [EXT_ADDR_W-1:0]   addr_ext;
    logic [WAY_W+1:0]        way_ext;

    assign addr_ext = EXT_ADDR_W'(i_address);

    // lookup, free-way and victim searches, lowest way wins
    always_comb begin
        found     = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        lru_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == r_addr_tag)) begin
                found   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!r_valid[i]) begin
                have_free = 1'b1;
                free_way  = WAY_W'(i);
            end
            if (r_age[i] == WAY_W'(WAYS - 1)) begin
                lru_way = WAY_W'(i);
            end
        end
    end

    always_comb begin
        priority if (found) begin
            sel_way = hit_way;
        end else if (have_free) begin
            sel_way = free_way;
        end else begin
            sel_way = lru_way;
        end
    end

    assign sel_age = r_age[sel_way];

    // move selected way to most recent, younger ways age by one
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) == sel_way) begin
                n_age[i] = '0;
            end else if (r_age[i] < sel_age) begin
                n_age[i] = r_age[i] + 1'b1;
            end else begin
                n_age[i] = r_age[i];
            end
        end
    end

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (found) begin
            if (r_hits != '1) begin
                n_hits = r_hits + 1'b1;
            end
        end else begin
            if (r_misses != '1) begin
                n_misses = r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAYS; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= WAY_W'(i);
            end
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.exec) begin
            r_age    <= n_age;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            if (!found) begin
                r_valid[sel_way] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_addr) begin
            r_addr_tag <= TAG_W'(addr_ext[ADDR_BITS-1:0] >> OFFSET_BITS);
        end
        if (i_cmd.exec) begin
            if (!found) begin
                r_tag[sel_way] <= r_addr_tag;
            end
            r_hit <= found;
            r_way <= sel_way;
        end
    end

    assign way_ext      = (WAY_W + 2)'(r_way);
    assign o_hit        = r_hit;
    assign o_way_used   = way_ext[WAY_OUT_W-1:0];
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

endmodule
